// ===== sv/pcnp_pkg.sv =====
package pcnp_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ROW_X_01 = 3'd0;
  localparam logic [2:0] REG_ROW_X_23 = 3'd1;
  localparam logic [2:0] REG_ROW_Y_01 = 3'd2;
  localparam logic [2:0] REG_ROW_Y_23 = 3'd3;
  localparam logic [2:0] REG_ROW_W_01 = 3'd4;
  localparam logic [2:0] REG_ROW_W_23 = 3'd5;

  // Field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned CoefW  = 64;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 24;

  // Projection accumulator and divider widths
  localparam int unsigned AccW   = 50;
  localparam int unsigned DivW   = 83;
  localparam int unsigned DivQW  = 48;
  localparam int unsigned StepW  = 6;
  localparam logic [StepW-1:0] ProjSteps = 6'd33;

  typedef struct packed {
    logic             start;
    logic [StepW-1:0] steps;
  } div_ctrl_t;

endpackage

// ===== sv/pcnp_div2.sv =====
// Two-lane restoring divider sharing one divisor; one quotient bit per cycle.
module pcnp_div2 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcnp_pkg::div_ctrl_t             ctrl_i,
  input  logic [pcnp_pkg::DivW-1:0]       rem_x_i,
  input  logic [pcnp_pkg::DivW-1:0]       rem_y_i,
  input  logic [pcnp_pkg::DivW-1:0]       den_i,
  output logic                            done_o,
  output logic [pcnp_pkg::DivQW-1:0]      quo_x_o,
  output logic [pcnp_pkg::DivQW-1:0]      quo_y_o
);

  logic [pcnp_pkg::DivW-1:0]  rx_q, ry_q, dsh_q;
  logic [pcnp_pkg::StepW-1:0] cnt_q;
  logic                       busy_q, done_q;
  logic                       ge_x, ge_y;

  assign ge_x = rx_q >= dsh_q;
  assign ge_y = ry_q >= dsh_q;

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rx_q    <= rem_x_i;
      ry_q    <= rem_y_i;
      dsh_q   <= den_i;
      quo_x_o <= '0;
      quo_y_o <= '0;
    end else if (busy_q) begin
      rx_q    <= ge_x ? rx_q - dsh_q : rx_q;
      ry_q    <= ge_y ? ry_q - dsh_q : ry_q;
      quo_x_o <= {quo_x_o[pcnp_pkg::DivQW-2:0], ge_x};
      quo_y_o <= {quo_y_o[pcnp_pkg::DivQW-2:0], ge_y};
      dsh_q   <= dsh_q >> 1;
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctrl_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == pcnp_pkg::StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

// ===== sv/projected_centroid_nearest_point.sv =====
// Channel  | Dir | Item fields (low bit first)
// s_axis   | in  | tdata: pos_x, pos_y, pos_z; tlast: last_point
// m_axis   | out | tdata: center_index, point_count, overflowed, zero pad
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (one 64-bit register per write)
//
// A held point passes through accept, multiply, divider setup, divide and store
// states in that order. A dropped point only sets the overflow flag. The last
// point adds a centroid divide and a scan of the point memory at one entry per
// cycle. Reset clears all control state; the memory needs no clear. A result
// waiting on m_axis_tready holds only the next last point.
module projected_centroid_nearest_point #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pcnp_pkg::InDataW-1:0]      s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic                              s_axis_tlast,  // last_point
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pcnp_pkg::OutDataW-1:0]     m_axis_tdata,  // center_index, point_count,
                                                           // overflowed
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [pcnp_pkg::CoefW-1:0]        cfg_data_i
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = 32 + $clog2(MAX_POINTS);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_POINTS);
  localparam logic [pcnp_pkg::StepW-1:0] CentSteps = pcnp_pkg::StepW'(SW);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_DSET = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_DEND = 4'd4;
  localparam logic [3:0] ST_CSET = 4'd5;
  localparam logic [3:0] ST_CDIV = 4'd6;
  localparam logic [3:0] ST_SCAN = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state_q, state_d;

  // configuration
  logic [63:0] rx01_q, rx23_q, ry01_q, ry23_q, rw01_q, rw23_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx01_q <= 64'h0001_0000_0000_0000;
      rx23_q <= '0;
      ry01_q <= 64'h0000_0000_0001_0000;
      ry23_q <= '0;
      rw01_q <= '0;
      rw23_q <= 64'h0000_0000_0001_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcnp_pkg::REG_ROW_X_01: rx01_q <= cfg_data_i;
        pcnp_pkg::REG_ROW_X_23: rx23_q <= cfg_data_i;
        pcnp_pkg::REG_ROW_Y_01: ry01_q <= cfg_data_i;
        pcnp_pkg::REG_ROW_Y_23: ry23_q <= cfg_data_i;
        pcnp_pkg::REG_ROW_W_01: rw01_q <= cfg_data_i;
        pcnp_pkg::REG_ROW_W_23: rw23_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // point and set state
  logic signed [31:0]  px_q, py_q, pz_q;
  logic                last_q;
  logic [CW-1:0]       cnt_q;
  logic                ovf_q;
  logic signed [SW-1:0] sum_x_q, sum_y_q;
  logic signed [31:0]  cx_q, cy_q;

  // projection
  logic [3:0]               k_q;
  logic [1:0]               prow_q;
  logic signed [63:0]       prod_q;
  logic signed [pcnp_pkg::AccW-1:0] acc_x_q, acc_y_q, acc_w_q;
  logic signed [31:0]       mul_a, mul_b;
  logic [1:0]               mul_row;
  logic signed [63:0]       term;

  // division flags
  logic den0_q, sat_x_q, sat_y_q;
  logic [pcnp_pkg::AccW-1:0] mag_x, mag_y, mag_w;
  logic [pcnp_pkg::DivW-1:0] rem_x, rem_y, den_sh;
  pcnp_pkg::div_ctrl_t       div_ctrl;
  logic                      div_done;
  logic [pcnp_pkg::DivQW-1:0] quo_x, quo_y;
  logic [31:0]               qx32, qy32;
  logic [SW-1:0]             smag_x, smag_y;

  // scan pipeline
  logic [63:0]          mem [MAX_POINTS];
  logic [63:0]          rd_q;
  logic [CW-1:0]        ra_q;
  logic                 issue_done_q;
  logic                 v1_q, v2_q, v3_q;
  logic [AW-1:0]        i1_q, i2_q, i3_q, best_i_q;
  logic [32:0]          adx_q, ady_q;
  logic [65:0]          sqx_q, sqy_q;
  logic [66:0]          best_q, dist_sum;
  logic                 have_q;
  logic signed [32:0]   dx, dy;

  // output register
  logic                 m_valid_q;
  logic [pcnp_pkg::OutDataW-1:0] m_data_q;

  function automatic logic [31:0] sat_quo(input logic den0, input logic sat,
                                          input logic nsgn, input logic nzero,
                                          input logic dsgn,
                                          input logic [pcnp_pkg::DivQW-1:0] q);
    logic neg;
    neg = nsgn ^ dsgn;
    if (den0) begin
      if (nzero) sat_quo = 32'h0000_0000;
      else if (nsgn) sat_quo = 32'h8000_0000;
      else sat_quo = 32'h7FFF_FFFF;
    end else if (neg) begin
      if (sat || q > pcnp_pkg::DivQW'(33'h0_8000_0000)) sat_quo = 32'h8000_0000;
      else sat_quo = 32'(-q);
    end else begin
      if (sat || q > pcnp_pkg::DivQW'(33'h0_7FFF_FFFF)) sat_quo = 32'h7FFF_FFFF;
      else sat_quo = q[31:0];
    end
  endfunction

  // coefficient and coordinate for product k (row-major over x, y, w rows)
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_row = 2'd0;
    case (k_q)
      4'd0: begin mul_a = rx01_q[63:32]; mul_b = px_q; mul_row = 2'd0; end
      4'd1: begin mul_a = rx01_q[31:0];  mul_b = py_q; mul_row = 2'd0; end
      4'd2: begin mul_a = rx23_q[63:32]; mul_b = pz_q; mul_row = 2'd0; end
      4'd3: begin mul_a = ry01_q[63:32]; mul_b = px_q; mul_row = 2'd1; end
      4'd4: begin mul_a = ry01_q[31:0];  mul_b = py_q; mul_row = 2'd1; end
      4'd5: begin mul_a = ry23_q[63:32]; mul_b = pz_q; mul_row = 2'd1; end
      4'd6: begin mul_a = rw01_q[63:32]; mul_b = px_q; mul_row = 2'd2; end
      4'd7: begin mul_a = rw01_q[31:0];  mul_b = py_q; mul_row = 2'd2; end
      4'd8: begin mul_a = rw23_q[63:32]; mul_b = pz_q; mul_row = 2'd2; end
      default: ;
    endcase
  end

  assign term = prod_q >>> 16;

  // divider operand setup
  assign mag_x  = acc_x_q[pcnp_pkg::AccW-1] ? pcnp_pkg::AccW'(-acc_x_q) : acc_x_q;
  assign mag_y  = acc_y_q[pcnp_pkg::AccW-1] ? pcnp_pkg::AccW'(-acc_y_q) : acc_y_q;
  assign mag_w  = acc_w_q[pcnp_pkg::AccW-1] ? pcnp_pkg::AccW'(-acc_w_q) : acc_w_q;
  assign smag_x = sum_x_q[SW-1] ? SW'(-sum_x_q) : sum_x_q;
  assign smag_y = sum_y_q[SW-1] ? SW'(-sum_y_q) : sum_y_q;

  always_comb begin
    div_ctrl.start = 1'b0;
    div_ctrl.steps = pcnp_pkg::ProjSteps;
    rem_x  = pcnp_pkg::DivW'(mag_x) << 16;
    rem_y  = pcnp_pkg::DivW'(mag_y) << 16;
    den_sh = pcnp_pkg::DivW'(mag_w) << 32;
    if (state_q == ST_DSET) begin
      div_ctrl.start = 1'b1;
    end else if (state_q == ST_CSET) begin
      div_ctrl.start = 1'b1;
      div_ctrl.steps = CentSteps;
      rem_x  = pcnp_pkg::DivW'(smag_x);
      rem_y  = pcnp_pkg::DivW'(smag_y);
      den_sh = pcnp_pkg::DivW'(cnt_q) << (SW - 1);
    end
  end

  pcnp_div2 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .rem_x_i (rem_x),
    .rem_y_i (rem_y),
    .den_i   (den_sh),
    .done_o  (div_done),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  assign qx32 = sat_quo(den0_q, sat_x_q, acc_x_q[pcnp_pkg::AccW-1], acc_x_q == '0,
                        acc_w_q[pcnp_pkg::AccW-1], quo_x);
  assign qy32 = sat_quo(den0_q, sat_y_q, acc_y_q[pcnp_pkg::AccW-1], acc_y_q == '0,
                        acc_w_q[pcnp_pkg::AccW-1], quo_y);

  // scan distance terms
  assign dx       = 33'($signed(rd_q[63:32])) - 33'(cx_q);
  assign dy       = 33'($signed(rd_q[31:0])) - 33'(cy_q);
  assign dist_sum = 67'(sqx_q) + 67'(sqy_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (cnt_q != MaxCnt) state_d = ST_MUL;
          else if (s_axis_tlast) state_d = ST_CSET;
        end
      end
      ST_MUL:  if (k_q == 4'd9) state_d = ST_DSET;
      ST_DSET: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_DEND;
      ST_DEND: state_d = last_q ? ST_CSET : ST_IDLE;
      ST_CSET: state_d = ST_CDIV;
      ST_CDIV: if (div_done) state_d = ST_SCAN;
      ST_SCAN: if (issue_done_q && !v1_q && !v2_q && !v3_q) state_d = ST_DONE;
      ST_DONE: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      ra_q         <= '0;
      issue_done_q <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      have_q       <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      // result register: load on a finished set, clear when taken
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          if (s_axis_tvalid && cnt_q == MaxCnt) ovf_q <= 1'b1;
        end
        ST_MUL: k_q <= k_q + 1'b1;
        ST_DEND: begin
          cnt_q   <= cnt_q + 1'b1;
          sum_x_q <= sum_x_q + SW'($signed(qx32));
          sum_y_q <= sum_y_q + SW'($signed(qy32));
        end
        ST_CSET: begin
          ra_q         <= '0;
          issue_done_q <= 1'b0;
          have_q       <= 1'b0;
        end
        ST_SCAN: begin
          v1_q <= !issue_done_q;
          v2_q <= v1_q;
          v3_q <= v2_q;
          if (!issue_done_q) begin
            ra_q <= ra_q + 1'b1;
            if (ra_q + 1'b1 == cnt_q) issue_done_q <= 1'b1;
          end
          if (v3_q && (!have_q || dist_sum < best_q)) have_q <= 1'b1;
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            cnt_q     <= '0;
            ovf_q     <= 1'b0;
            sum_x_q   <= '0;
            sum_y_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      px_q   <= s_axis_tdata[31:0];
      py_q   <= s_axis_tdata[63:32];
      pz_q   <= s_axis_tdata[95:64];
      last_q <= s_axis_tlast;
      acc_x_q <= pcnp_pkg::AccW'($signed(rx23_q[31:0]));
      acc_y_q <= pcnp_pkg::AccW'($signed(ry23_q[31:0]));
      acc_w_q <= pcnp_pkg::AccW'($signed(rw23_q[31:0]));
    end
    // multiply, then fold the floored term into its row next cycle
    if (state_q == ST_MUL) begin
      prod_q <= mul_a * mul_b;
      prow_q <= mul_row;
      if (k_q != 4'd0) begin
        case (prow_q)
          2'd0:    acc_x_q <= acc_x_q + pcnp_pkg::AccW'(term);
          2'd1:    acc_y_q <= acc_y_q + pcnp_pkg::AccW'(term);
          default: acc_w_q <= acc_w_q + pcnp_pkg::AccW'(term);
        endcase
      end
    end
    // quotient at or above 2^33 saturates regardless of sign
    if (state_q == ST_DSET) begin
      den0_q  <= mag_w == '0;
      sat_x_q <= (pcnp_pkg::DivW'(mag_x) << 16) >= (pcnp_pkg::DivW'(mag_w) << 33);
      sat_y_q <= (pcnp_pkg::DivW'(mag_y) << 16) >= (pcnp_pkg::DivW'(mag_w) << 33);
    end
    if (state_q == ST_DEND) mem[cnt_q[AW-1:0]] <= {qx32, qy32};
    if (state_q == ST_CDIV && div_done) begin
      cx_q <= sum_x_q[SW-1] ? 32'(-quo_x) : quo_x[31:0];
      cy_q <= sum_y_q[SW-1] ? 32'(-quo_y) : quo_y[31:0];
    end
    // scan: read, difference, square, compare
    rd_q  <= mem[ra_q[AW-1:0]];
    i1_q  <= ra_q[AW-1:0];
    i2_q  <= i1_q;
    i3_q  <= i2_q;
    adx_q <= dx[32] ? 33'(-dx) : 33'(dx);
    ady_q <= dy[32] ? 33'(-dy) : 33'(dy);
    sqx_q <= adx_q * adx_q;
    sqy_q <= ady_q * ady_q;
    if (state_q == ST_SCAN && v3_q && (!have_q || dist_sum < best_q)) begin
      best_q   <= dist_sum;
      best_i_q <= i3_q;
    end
    if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {2'b00, ovf_q, pcnp_pkg::CountW'(cnt_q),
                   pcnp_pkg::IndexW'(best_i_q)};
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== sv/pcnp_chk.sv =====
module pcnp_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pcnp_pkg::OutDataW-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  // every set holds at least one point
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:10] != 11'd0)
    else $error("result with empty set");

  // winner lies inside the set
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 11'(m_axis_tdata[9:0]) < m_axis_tdata[20:10])
    else $error("center index beyond point count");

  // a new result never shows up right after an accepted input item
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared right after an item");

endmodule

bind projected_centroid_nearest_point pcnp_chk u_pcnp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
